@@ hw/rtl/bmpdec_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpdec_pkg
// Types and constants shared by the 24-bit BMP stream decoder modules.
// ----------------------------------------------------------------------------
package bmpdec_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_PAD    = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_DEPTH  = 2'd2;
  localparam logic [1:0] KIND_SIZE   = 2'd3;

  // Header byte positions of interest
  localparam logic [5:0] POS_MAGIC_B = 6'd0;
  localparam logic [5:0] POS_MAGIC_M = 6'd1;
  localparam logic [5:0] POS_COLS    = 6'd21;
  localparam logic [5:0] POS_ROWS    = 6'd25;
  localparam logic [5:0] POS_DEPTH   = 6'd29;
  localparam logic [5:0] POS_LAST    = 6'd53;

  localparam logic [7:0]  MAGIC_B   = 8'h42;
  localparam logic [7:0]  MAGIC_M   = 8'h4D;
  localparam logic [15:0] BMP_DEPTH = 16'd24;

  localparam int unsigned DIM_OUT_W = 13;
  localparam int unsigned IDX_W     = 24;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [1:0]           result_kind;
    logic                 magic_ok;
    logic [DIM_OUT_W-1:0] stored_rows;
    logic [DIM_OUT_W-1:0] stored_cols;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [IDX_W-1:0]     pixel_index;
    logic                 last_pixel;
  } out_beat_t;

endpackage

@@ hw/rtl/bmp24_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Byte-stream decoder for uncompressed 24-bit BMP files.
// ----------------------------------------------------------------------------
// Accepts one file byte per clock cycle and gives at most one result per
// byte: a header-info beat after header byte 53, an error beat for a bad depth
// or an oversize image, and one RGB pixel beat for each BGR triple. Each byte
// passes an input register and is parsed combinationally into the result
// register. The sustained rate is one byte per cycle; input stalls only
// while a result waits in the output register and the downstream side is
// not ready. pad_to_pow2 is sampled at header byte 53.
module bmp24_stream_decoder #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bmpdec_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bmpdec_pkg::out_beat_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);
  import bmpdec_pkg::*;

  logic      pad_to_pow2_q;
  logic      in_valid_q;
  in_beat_t  in_q;
  logic      out_valid_q;
  out_beat_t out_q;
  logic      adv;
  logic      res_valid;
  out_beat_t res;

  // Parse when a byte is held and its result has somewhere to go
  assign adv         = in_valid_q && (!out_valid_q || out_ready_i || !res_valid);
  assign in_ready_o  = !in_valid_q || adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_to_pow2_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pad_to_pow2_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  bmpdec_parser #(
    .MAX_DIM(MAX_DIM)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .beat_i       (in_q),
    .pad_to_pow2_i(pad_to_pow2_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register: load a new beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

endmodule

@@ hw/rtl/bmpdec_parser.sv @@
// ----------------------------------------------------------------------------
// bmpdec_parser
// Per-byte BMP parser state and result logic; state advances on adv_i.
// ----------------------------------------------------------------------------
module bmpdec_parser #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  bmpdec_pkg::in_beat_t  beat_i,
  input  logic                  pad_to_pow2_i,
  output logic                  res_valid_o,
  output bmpdec_pkg::out_beat_t res_o
);
  import bmpdec_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam logic [31:0]    MAX_DIM_32 = 32'(MAX_DIM);
  localparam logic [DIM_W:0] MAX_DIM_C  = (DIM_W + 1)'(MAX_DIM);

  // Smallest power of two not below n; zero rounds to one
  function automatic logic [DIM_W:0] ceil_pow2(input logic [DIM_W-1:0] n);
    logic [DIM_W:0] m;
    int             s;
    m = {1'b0, n} - (DIM_W + 1)'(1);
    for (s = 1; s <= int'(DIM_W); s = s << 1) begin
      m = m | (m >> s);
    end
    if (n == '0) begin
      return (DIM_W + 1)'(1);
    end
    return m + (DIM_W + 1)'(1);
  endfunction

  phase_e           phase_q, phase_d;
  logic [5:0]       pos_q, pos_d;
  logic [31:0]      field_q, field_d;
  logic [DIM_W-1:0] cols_q, cols_d, rows_q, rows_d;
  logic             cols_over_q, cols_over_d, rows_over_q, rows_over_d;
  logic [DIM_W:0]   cols_ceil_q, rows_ceil_q;
  logic [DIM_W-1:0] pcols_q, pcols_d, prows_q, prows_d;
  logic             magic_q, magic_d;
  logic [1:0]       slot_q, slot_d;
  logic [15:0]      held_q, held_d;
  logic [DIM_W-1:0] colc_q, colc_d, rowc_q, rowc_d;
  logic [1:0]       padc_q, padc_d;
  logic [IDX_W-1:0] base_q, base_d;

  phase_e           cur_phase;
  logic [5:0]       cur_pos;
  logic [31:0]      shift_nx;
  logic [DIM_W-1:0] colc_nx, rowc_nx;
  logic [DIM_W-1:0] pcols_nx, prows_nx;
  logic             size_bad;

  // Next state and result for the byte at the parser input
  always_comb begin
    cur_phase = beat_i.file_start ? PH_HEADER : phase_q;
    cur_pos   = beat_i.file_start ? '0 : pos_q;
    shift_nx  = {beat_i.data_byte, field_q[31:8]};
    colc_nx   = colc_q + DIM_W'(1);
    rowc_nx   = rowc_q + DIM_W'(1);
    pcols_nx  = pad_to_pow2_i ? cols_ceil_q[DIM_W-1:0] : cols_q;
    prows_nx  = pad_to_pow2_i ? rows_ceil_q[DIM_W-1:0] : rows_q;
    size_bad  = cols_over_q || rows_over_q ||
                (pad_to_pow2_i && ((cols_ceil_q > MAX_DIM_C) || (rows_ceil_q > MAX_DIM_C)));

    phase_d     = cur_phase;
    pos_d       = pos_q;
    field_d     = field_q;
    cols_d      = cols_q;
    rows_d      = rows_q;
    cols_over_d = cols_over_q;
    rows_over_d = rows_over_q;
    pcols_d     = pcols_q;
    prows_d     = prows_q;
    magic_d     = magic_q;
    slot_d      = slot_q;
    held_d      = held_q;
    colc_d      = colc_q;
    rowc_d      = rowc_q;
    padc_d      = padc_q;
    base_d      = base_q;

    res_valid_o       = 1'b0;
    res_o             = '0;
    res_o.magic_ok    = magic_q;

    case (cur_phase)
      PH_HEADER: begin
        field_d = shift_nx;
        pos_d   = cur_pos + 6'd1;
        if (cur_pos == POS_MAGIC_B) begin
          magic_d = (beat_i.data_byte == MAGIC_B);
        end else if (cur_pos == POS_MAGIC_M) begin
          magic_d = magic_q && (beat_i.data_byte == MAGIC_M);
        end else if (cur_pos == POS_COLS) begin
          cols_d      = shift_nx[DIM_W-1:0];
          cols_over_d = (shift_nx > MAX_DIM_32);
        end else if (cur_pos == POS_ROWS) begin
          rows_d      = shift_nx[DIM_W-1:0];
          rows_over_d = (shift_nx > MAX_DIM_32);
        end else if (cur_pos == POS_DEPTH && shift_nx[31:16] != BMP_DEPTH) begin
          phase_d           = PH_DONE;
          res_valid_o       = 1'b1;
          res_o.result_kind = KIND_DEPTH;
        end else if (cur_pos == POS_LAST) begin
          res_valid_o = 1'b1;
          if (size_bad) begin
            phase_d           = PH_DONE;
            res_o.result_kind = KIND_SIZE;
          end else begin
            pcols_d           = pcols_nx;
            prows_d           = prows_nx;
            phase_d           = (cols_q == '0 || rows_q == '0) ? PH_DONE : PH_PIXELS;
            slot_d            = 2'd0;
            colc_d            = '0;
            rowc_d            = '0;
            base_d            = '0;
            res_o.result_kind = KIND_HEADER;
            res_o.stored_rows = DIM_OUT_W'(prows_nx);
            res_o.stored_cols = DIM_OUT_W'(pcols_nx);
          end
        end
      end
      PH_PAD: begin
        // drop one pad byte
        padc_d = padc_q - 2'd1;
        if (padc_q == 2'd1) begin
          phase_d = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        case (slot_q)
          2'd0: begin
            held_d[7:0] = beat_i.data_byte;
            slot_d      = 2'd1;
          end
          2'd1: begin
            held_d[15:8] = beat_i.data_byte;
            slot_d       = 2'd2;
          end
          default: begin
            slot_d            = 2'd0;
            res_valid_o       = 1'b1;
            res_o.result_kind = KIND_PIXEL;
            res_o.stored_rows = DIM_OUT_W'(prows_q);
            res_o.stored_cols = DIM_OUT_W'(pcols_q);
            res_o.red         = beat_i.data_byte;
            res_o.green       = held_q[15:8];
            res_o.blue        = held_q[7:0];
            res_o.pixel_index = base_q + IDX_W'(colc_q);
            colc_d            = colc_nx;
            if (colc_nx >= cols_q) begin
              if (rowc_nx >= rows_q) begin
                res_o.last_pixel = 1'b1;
                phase_d          = PH_DONE;
              end else begin
                rowc_d  = rowc_nx;
                base_d  = base_q + IDX_W'(pcols_q);
                colc_d  = '0;
                padc_d  = 2'(cols_q);
                phase_d = (2'(cols_q) != 2'd0) ? PH_PAD : PH_PIXELS;
              end
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      cols_q      <= '0;
      rows_q      <= '0;
      cols_over_q <= 1'b0;
      rows_over_q <= 1'b0;
      pcols_q     <= '0;
      prows_q     <= '0;
      magic_q     <= 1'b0;
      slot_q      <= 2'd0;
      colc_q      <= '0;
      rowc_q      <= '0;
      padc_q      <= 2'd0;
      base_q      <= '0;
    end else if (adv_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      cols_over_q <= cols_over_d;
      rows_over_q <= rows_over_d;
      pcols_q     <= pcols_d;
      prows_q     <= prows_d;
      magic_q     <= magic_d;
      slot_q      <= slot_d;
      colc_q      <= colc_d;
      rowc_q      <= rowc_d;
      padc_q      <= padc_d;
      base_q      <= base_d;
    end
  end

  // Shift register, held color bytes and rounded dimensions
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      field_q <= field_d;
      held_q  <= held_d;
    end
    cols_ceil_q <= ceil_pow2(cols_q);
    rows_ceil_q <= ceil_pow2(rows_q);
  end

endmodule
